FILE: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that an antecedent is followed in the next cycle by a consequent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mmr_pkg.sv
`timescale 1ns / 1ps

package mmr_pkg;

    // Action codes of the input word.
    localparam logic [3:0] ACT_NOTE_ON      = 4'd0;
    localparam logic [3:0] ACT_NOTE_OFF     = 4'd1;
    localparam logic [3:0] ACT_POLY_PRESS   = 4'd2;
    localparam logic [3:0] ACT_CC           = 4'd3;
    localparam logic [3:0] ACT_PROGRAM      = 4'd4;
    localparam logic [3:0] ACT_CHAN_PRESS   = 4'd5;
    localparam logic [3:0] ACT_PITCH_BEND   = 4'd6;
    localparam logic [3:0] ACT_GENERIC      = 4'd7;
    localparam logic [3:0] ACT_DRAIN        = 4'd8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KIND_ENABLES = 2'd0;
    localparam logic [1:0] CFG_CLOSED_MODE  = 2'd1;
    localparam logic [1:0] CFG_MAP_VALID    = 2'd2;
    localparam logic [1:0] CFG_MAP_TARGET   = 2'd3;

    // Upper nibbles of the channel message status bytes.
    localparam logic [3:0] STAT_NOTE_OFF    = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON     = 4'h9;
    localparam logic [3:0] STAT_POLY_PRESS  = 4'hA;
    localparam logic [3:0] STAT_CC          = 4'hB;
    localparam logic [3:0] STAT_PROGRAM     = 4'hC;
    localparam logic [3:0] STAT_CHAN_PRESS  = 4'hD;
    localparam logic [3:0] STAT_PITCH_BEND  = 4'hE;

    localparam logic [7:0] DRAIN_VELOCITY   = 8'h40;

    // Held-note bitmap: 2048 entries kept as 256 rows of 8 bits.
    localparam int ROW_BITS = 8;
    localparam int ROWS     = 256;
    localparam logic [7:0] ROW_LAST = 8'(ROWS - 1);

    typedef logic [7:0] row_t;

    typedef struct packed {
        logic capture;
        logic clear_step;
        logic rd_scan;
        logic load_msg;
        logic note_write;
        logic scan_init;
        logic scan_next;
        logic drain_write;
    } mmr_cmd_t;

    typedef struct packed {
        logic is_drain;
        logic invalid_act;
        logic closed;
        logic drop_generic;
        logic note_kind;
        logic total_nz;
        logic row_nz;
        logic row_last;
    } mmr_sts_t;

endpackage

FILE: src/mmr_ctrl.sv
`timescale 1ns / 1ps

module mmr_ctrl
    import mmr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  mmr_sts_t sts,
    output mmr_cmd_t cmd,
    output logic     busy
);

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_DECODE   = 6'b000100,
        S_NOTE_WR  = 6'b001000,
        S_SCAN_RD  = 6'b010000,
        S_SCAN_CHK = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.row_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // The note row is read here so that its word is ready in S_NOTE_WR.
                priority if (sts.is_drain)
                begin
                    if (sts.closed && sts.total_nz)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (sts.invalid_act || sts.closed || sts.drop_generic)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.note_kind)
                begin
                    state_next = S_NOTE_WR;
                end
                else
                begin
                    cmd.load_msg = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_NOTE_WR:
            begin
                cmd.note_write = 1'b1;
                cmd.load_msg   = 1'b1;
                state_next     = S_IDLE;
            end
            S_SCAN_RD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                priority if (sts.row_nz)
                begin
                    cmd.drain_write = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (sts.row_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: src/mmr_datapath.sv
`timescale 1ns / 1ps

module mmr_datapath
    import mmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mmr_cmd_t    cmd,
    output mmr_sts_t    sts,
    input  logic [3:0]  action,
    input  logic [3:0]  channel,
    input  logic [6:0]  note_number,
    input  logic [13:0] value,
    input  logic [1:0]  byte_count,
    input  logic [7:0]  first_byte,
    input  logic [7:0]  second_byte,
    input  logic [7:0]  third_byte,
    input  logic        handled,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        done,
    output logic        port,
    output logic [1:0]  out_length,
    output logic [7:0]  out_status,
    output logic [7:0]  out_data1,
    output logic [7:0]  out_data2,
    output logic        more_held
);

    // Captured input word.
    logic [3:0]  act_reg;
    logic [3:0]  ch_reg;
    logic [6:0]  num_reg;
    logic [13:0] val_reg;
    logic [1:0]  cnt_reg;
    logic [7:0]  b1_reg;
    logic [7:0]  b2_reg;
    logic [7:0]  b3_reg;
    logic        hnd_reg;

    // Configuration.
    logic [7:0]  kind_en_reg;
    logic        closed_reg;
    logic [15:0] map_valid_reg;
    logic [63:0] map_target_reg;

    // Held-note state.
    logic [ROW_BITS-1:0] held_mem [ROWS];
    logic [ROW_BITS-1:0] rd_data_reg;
    row_t                row_reg;
    row_t                row_next;
    logic [11:0]         total_reg;
    logic [11:0]         total_next;

    logic                mem_we;
    row_t                mem_wa;
    row_t                mem_ra;
    logic [ROW_BITS-1:0] mem_wd;

    logic                done_reg;
    logic                port_reg;
    logic [1:0]          len_reg;
    logic [7:0]          status_reg;
    logic [7:0]          data1_reg;
    logic [7:0]          data2_reg;
    logic                more_reg;

    logic                en;
    logic [3:0]          remapped;
    logic [3:0]          och;
    row_t                note_row;
    logic [2:0]          note_bit;
    logic                note_on;
    logic                was_held;
    logic [2:0]          low_bit;
    logic                low_found;

    logic [1:0]          msg_len;
    logic [7:0]          msg_status;
    logic [7:0]          msg_data1;
    logic [7:0]          msg_data2;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            ch_reg  <= channel;
            num_reg <= note_number;
            val_reg <= value;
            cnt_reg <= byte_count;
            b1_reg  <= first_byte;
            b2_reg  <= second_byte;
            b3_reg  <= third_byte;
            hnd_reg <= handled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_en_reg    <= 8'hFF;
            closed_reg     <= 1'b0;
            map_valid_reg  <= 16'h0000;
            map_target_reg <= 64'h0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KIND_ENABLES: kind_en_reg    <= cfg_data[7:0];
                CFG_CLOSED_MODE:  closed_reg     <= cfg_data[0];
                CFG_MAP_VALID:    map_valid_reg  <= cfg_data[15:0];
                CFG_MAP_TARGET:   map_target_reg <= cfg_data;
            endcase
        end
    end

    assign en       = kind_en_reg[act_reg[2:0]];
    assign remapped = map_valid_reg[ch_reg] ? map_target_reg[{ch_reg, 2'b00} +: 4] : ch_reg;
    assign och      = en ? remapped : ch_reg;
    assign note_row = {num_reg, och[3]};
    assign note_bit = och[2:0];
    assign note_on  = (act_reg == ACT_NOTE_ON);
    assign was_held = rd_data_reg[note_bit];

    always_comb
    begin
        low_bit   = '0;
        low_found = 1'b0;
        for (int i = 0; i < ROW_BITS; i++)
        begin
            if (!low_found && rd_data_reg[i])
            begin
                low_bit   = 3'(i);
                low_found = 1'b1;
            end
        end
    end

    // One memory port pair: the scan walks rows, a note touches its own row.
    always_comb
    begin
        mem_ra = cmd.rd_scan ? row_reg : note_row;
        mem_we = cmd.clear_step | cmd.note_write | cmd.drain_write;
        mem_wa = cmd.note_write ? note_row : row_reg;
        priority if (cmd.note_write)
        begin
            mem_wd = note_on ? (rd_data_reg | (8'b1 << note_bit))
                             : (rd_data_reg & ~(8'b1 << note_bit));
        end
        else if (cmd.drain_write)
        begin
            mem_wd = rd_data_reg & (rd_data_reg - 8'd1);
        end
        else
        begin
            mem_wd = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            held_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= held_mem[mem_ra];
    end

    always_comb
    begin
        row_next   = row_reg;
        total_next = total_reg;
        if (cmd.scan_init)
        begin
            row_next = '0;
        end
        else if (cmd.clear_step || cmd.scan_next)
        begin
            row_next = row_reg + 8'd1;
        end
        if (cmd.note_write)
        begin
            if (note_on && !was_held)
            begin
                total_next = total_reg + 12'd1;
            end
            else if (!note_on && was_held)
            begin
                total_next = total_reg - 12'd1;
            end
        end
        else if (cmd.drain_write)
        begin
            total_next = total_reg - 12'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            row_reg   <= row_next;
            total_reg <= total_next;
            done_reg  <= cmd.load_msg | cmd.drain_write;
        end
    end

    always_comb
    begin
        msg_len    = 2'd3;
        msg_status = {STAT_NOTE_ON, och};
        msg_data1  = {1'b0, num_reg};
        msg_data2  = val_reg[7:0];
        unique case (act_reg)
            ACT_NOTE_ON:    msg_status = {STAT_NOTE_ON, och};
            ACT_NOTE_OFF:   msg_status = {STAT_NOTE_OFF, och};
            ACT_POLY_PRESS: msg_status = {STAT_POLY_PRESS, och};
            ACT_CC:         msg_status = {STAT_CC, och};
            ACT_PROGRAM, ACT_CHAN_PRESS:
            begin
                msg_len    = 2'd2;
                msg_status = {(act_reg == ACT_PROGRAM) ? STAT_PROGRAM : STAT_CHAN_PRESS, och};
                msg_data1  = val_reg[7:0];
                msg_data2  = 8'h00;
            end
            ACT_PITCH_BEND:
            begin
                msg_status = {STAT_PITCH_BEND, och};
                msg_data1  = {1'b0, val_reg[6:0]};
                msg_data2  = {1'b0, val_reg[13:7]};
            end
            default:
            begin
                // Generic message: bytes past its length read as zero.
                msg_len    = cnt_reg;
                msg_status = b1_reg;
                msg_data1  = (cnt_reg >= 2'd2) ? b2_reg : 8'h00;
                msg_data2  = (cnt_reg == 2'd3) ? b3_reg : 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.drain_write)
        begin
            port_reg   <= 1'b0;
            len_reg    <= 2'd3;
            status_reg <= {STAT_NOTE_OFF, row_reg[0], low_bit};
            data1_reg  <= {1'b0, row_reg[7:1]};
            data2_reg  <= DRAIN_VELOCITY;
            more_reg   <= (total_reg != 12'd1);
        end
        else if (cmd.load_msg)
        begin
            port_reg   <= ~en;
            len_reg    <= msg_len;
            status_reg <= msg_status;
            data1_reg  <= msg_data1;
            data2_reg  <= msg_data2;
            more_reg   <= 1'b0;
        end
    end

    always_comb
    begin
        sts.is_drain     = (act_reg == ACT_DRAIN);
        sts.invalid_act  = (act_reg > ACT_DRAIN);
        sts.closed       = closed_reg;
        sts.drop_generic = (act_reg == ACT_GENERIC) && (hnd_reg || (cnt_reg == 2'd0));
        sts.note_kind    = en && ((act_reg == ACT_NOTE_ON) || (act_reg == ACT_NOTE_OFF));
        sts.total_nz     = (total_reg != 12'd0);
        sts.row_nz       = (rd_data_reg != '0);
        sts.row_last     = (row_reg == ROW_LAST);
    end

    assign done       = done_reg;
    assign port       = port_reg;
    assign out_length = len_reg;
    assign out_status = status_reg;
    assign out_data1  = data1_reg;
    assign out_data2  = data2_reg;
    assign more_held  = more_reg;

endmodule

FILE: src/midi_message_router.sv
`timescale 1ns / 1ps
// MIDI message router.
// Input: a decoded message word is taken at a rising edge with start high and busy low.
// Result: at most one word per input, shown for exactly one cycle with done high.
// port 0 is the main port (enabled kinds, channel remapped), port 1 the bypass port.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects kind_enables,
// closed_mode, map_valid or map_target; cfg_ready is always high.
// Flow: a plain message goes to the result registers straight from decode; an enabled
// note-on or note-off first passes a write state that updates its bitmap row.
// busy drops in the done cycle, so the next word can be accepted then.
// When closed_mode is set and notes are held, a drain tick scans the 256-row held-note
// memory row by row from row 0, reading and checking each, up to the lowest held note.
// Items that produce no result return the block to idle without raising done.
// Reset: config returns to its defaults and a clearing pass over the 256 memory
// rows runs with busy high; configuration writes are taken meanwhile.
// The receiver cannot stall: each result is valid for its single done cycle only.
module midi_message_router
    import mmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  action,
    input  logic [3:0]  channel,
    input  logic [6:0]  note_number,
    input  logic [13:0] value,
    input  logic [1:0]  byte_count,
    input  logic [7:0]  first_byte,
    input  logic [7:0]  second_byte,
    input  logic [7:0]  third_byte,
    input  logic        handled,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        done,
    output logic        port,
    output logic [1:0]  out_length,
    output logic [7:0]  out_status,
    output logic [7:0]  out_data1,
    output logic [7:0]  out_data2,
    output logic        more_held
);

    mmr_cmd_t cmd;
    mmr_sts_t sts;

    assign cfg_ready = 1'b1;

    mmr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    mmr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .action      (action),
        .channel     (channel),
        .note_number (note_number),
        .value       (value),
        .byte_count  (byte_count),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .third_byte  (third_byte),
        .handled     (handled),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .port        (port),
        .out_length  (out_length),
        .out_status  (out_status),
        .out_data1   (out_data1),
        .out_data2   (out_data2),
        .more_held   (more_held)
    );

endmodule

FILE: src/mmr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       port,
    input logic [1:0] out_length,
    input logic [7:0] out_data2,
    input logic       more_held
);

    logic drain_shape;

    // A drain note-off leaves on the main port with three bytes and velocity 64.
    assign drain_shape = !port && (out_length == 2'd3) && (out_data2 == 8'h40);

    // A result word only follows work that kept the block busy.
    `ASSERT_CLK(a_done_after_busy, done |-> $past(busy), "result word without preceding work")

    // An accepted word always occupies the block in the next cycle.
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")

    // Results are single-cycle strobes and never come back to back.
    `ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")

    // Only a drain note-off reports remaining held notes.
    `ASSERT_CLK(a_more_is_drain, done && more_held |-> drain_shape, "more_held on a message word")

endmodule

bind midi_message_router mmr_checker u_mmr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .port       (port),
    .out_length (out_length),
    .out_data2  (out_data2),
    .more_held  (more_held)
);
